// ===== hdl/assert_macros.svh =====
// Assertion macros used by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset.
`define DSPDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DSPDF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define DSPDF_ASSERT(label, prop, msg)
`define DSPDF_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== hdl/dspdf_pkg.sv =====
// Types and constants of the delimiter sync parity deframer.
package dspdf_pkg;

    localparam int TICK_COUNT_WIDTH = 32;
    localparam int TIMEOUT_W        = 32;
    localparam int CMP_W            = (TICK_COUNT_WIDTH > TIMEOUT_W) ?
                                      TICK_COUNT_WIDTH : TIMEOUT_W;
    localparam int DATA_BITS        = 8;
    localparam int BITS_TAKEN_W     = 4;
    localparam int CFG_IDX_W        = 8;
    localparam int CFG_DATA_W       = 32;

    localparam logic [7:0] DEFAULT_START_PATTERN = 8'b1001_1010;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PATTERN = 8'd0,
        CFG_PARITY_ODD    = 8'd1,
        CFG_TIMEOUT_TICKS = 8'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_BIT  = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_VALID_FRAME  = 2'd0,
        ST_PARITY_ERROR = 2'd1,
        ST_TIMEOUT      = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type req_type;
        logic      bit_value;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        logic       parity_bit;
    } t_out_item;

endpackage

// ===== hdl/dspdf_if.sv =====
// Valid/ready channel interfaces for deframer input and result items.
interface dspdf_in_if
    import dspdf_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dspdf_out_if
    import dspdf_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/delimiter_sync_parity_deframer_top.sv =====
// An accepted input item is held in the input register, goes through the decode
// pass and its result item waits in the result register until it is taken.
// Throughput: one item per cycle, set by the input register feeding the single
// decode pass into the result register; a stalled result holds the input side.
// Reset: synchronous and active low; it clears the frame state, empties both
// registers and loads the configuration defaults. No clearing pass is needed.
`include "assert_macros.svh"

module delimiter_sync_parity_deframer_top
    import dspdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dspdf_in_if.sink              i_item,
    dspdf_out_if.source           o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [7:0]           r_start_pattern;
    logic                 r_parity_odd;
    logic [TIMEOUT_W-1:0] r_timeout_ticks;

    // Input register: holds one accepted item until the decode pass takes it.
    logic     r_in_valid;
    t_in_item r_in_item;

    // Frame state.
    logic                        r_receiving,  n_receiving;
    logic [7:0]                  r_hunt_shift, n_hunt_shift;
    logic [BITS_TAKEN_W-1:0]     r_bits_taken, n_bits_taken;
    logic [7:0]                  r_data_shift, n_data_shift;
    logic [TICK_COUNT_WIDTH-1:0] r_hunt_ticks, n_hunt_ticks;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      n_res_valid;
    t_out_item n_res_item;

    logic                        advance;
    logic                        in_ready;
    logic [TICK_COUNT_WIDTH-1:0] ticks_sat;
    logic [7:0]                  hunt_next;

    // The buffered item moves through decode whenever the result slot is
    // free or is being emptied in this same cycle.
    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready    = in_ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out_item;

    // The tick counter saturates at all ones.
    assign ticks_sat = (r_hunt_ticks == '1) ? r_hunt_ticks :
                       TICK_COUNT_WIDTH'(r_hunt_ticks + 1'b1);
    assign hunt_next = {r_hunt_shift[6:0], r_in_item.bit_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pattern <= DEFAULT_START_PATTERN;
            r_parity_odd    <= 1'b0;
            r_timeout_ticks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_PATTERN: r_start_pattern <= i_cfg_data[7:0];
                CFG_PARITY_ODD:    r_parity_odd    <= i_cfg_data[0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Single decode pass over the buffered item.
    always_comb begin
        n_receiving  = r_receiving;
        n_hunt_shift = r_hunt_shift;
        n_bits_taken = r_bits_taken;
        n_data_shift = r_data_shift;
        n_hunt_ticks = r_hunt_ticks;
        n_res_valid  = 1'b0;
        n_res_item   = '{status: ST_VALID_FRAME, data_byte: 8'd0, parity_bit: 1'b0};

        if (r_in_item.req_type == REQ_TICK) begin
            // Ticks only count while hunting.
            if (!r_receiving) begin
                n_hunt_ticks = ticks_sat;
                if ((r_timeout_ticks != '0) &&
                    (CMP_W'(ticks_sat) > CMP_W'(r_timeout_ticks))) begin
                    n_res_valid           = 1'b1;
                    n_res_item.status     = ST_TIMEOUT;
                    n_hunt_shift          = '0;
                    n_bits_taken          = '0;
                    n_data_shift          = '0;
                    n_hunt_ticks          = '0;
                end
            end
        end else if (!r_receiving) begin
            n_hunt_shift = hunt_next;
            if (hunt_next == r_start_pattern) begin
                n_receiving  = 1'b1;
                n_bits_taken = '0;
                n_data_shift = '0;
            end
        end else if (r_bits_taken < BITS_TAKEN_W'(DATA_BITS)) begin
            n_data_shift = {r_data_shift[6:0], r_in_item.bit_value};
            n_bits_taken = BITS_TAKEN_W'(r_bits_taken + 1'b1);
        end else begin
            // Parity bit closes the frame; a new hunt starts from scratch.
            n_res_valid           = 1'b1;
            n_res_item.status     = ((^r_data_shift ^ r_in_item.bit_value) == r_parity_odd) ?
                                    ST_VALID_FRAME : ST_PARITY_ERROR;
            n_res_item.data_byte  = r_data_shift;
            n_res_item.parity_bit = r_in_item.bit_value;
            n_receiving           = 1'b0;
            n_hunt_shift          = '0;
            n_bits_taken          = '0;
            n_data_shift          = '0;
            n_hunt_ticks          = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_receiving  <= 1'b0;
            r_hunt_shift <= '0;
            r_bits_taken <= '0;
            r_data_shift <= '0;
            r_hunt_ticks <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid  <= n_res_valid;
                r_receiving  <= n_receiving;
                r_hunt_shift <= n_hunt_shift;
                r_bits_taken <= n_bits_taken;
                r_data_shift <= n_data_shift;
                r_hunt_ticks <= n_hunt_ticks;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_in_item <= i_item.data;
        end
        if (advance && n_res_valid) begin
            r_out_item <= n_res_item;
        end
    end

    `DSPDF_ASSERT(a_bits_bounded, (r_bits_taken <= BITS_TAKEN_W'(DATA_BITS)),
                  "bit count beyond frame")
    `DSPDF_ASSERT(a_hunt_clean,
                  (!r_receiving |-> (r_bits_taken == '0 && r_data_shift == '0)),
                  "data state dirty while hunting")
    `DSPDF_ASSERT(a_timeout_zero,
                  ((r_out_valid && r_out_item.status == ST_TIMEOUT) |->
                   (r_out_item.data_byte == 8'd0 && !r_out_item.parity_bit)),
                  "timeout item carries data")
    `DSPDF_ASSERT(a_tick_ignored,
                  ((advance && r_in_item.req_type == REQ_TICK && r_receiving) |=>
                   (r_receiving && $stable(r_bits_taken) && $stable(r_data_shift))),
                  "tick disturbed a frame")
    `DSPDF_ASSERT_ALWAYS(a_reset_empty,
                         (!i_rst_n |=> (!r_in_valid && !r_out_valid && !r_receiving)),
                         "pipeline not empty after reset")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the delimiter sync parity deframer top level.
module testbench;
    import dspdf_pkg::*;

    // The top level hands over a result once its input item has passed the input register and the result register.
    localparam int LATENCY = 2;
    // Cycles allowed after the last report before the block counts as idle.
    localparam int SETTLE = LATENCY + 4;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Index one past the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dspdf_in_if  item_ch ();
    dspdf_out_if result_ch ();

    delimiter_sync_parity_deframer_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Our own copy of the register file, updated whenever we program the block.
    logic [7:0]  pattern_cfg;
    logic        odd_cfg;
    logic [31:0] timeout_cfg;

    // Our own copy of the frame state.
    logic                        in_frame;
    logic [7:0]                  hunt_reg;
    logic [3:0]                  bits_seen;
    logic [7:0]                  data_reg;
    logic [TICK_COUNT_WIDTH-1:0] tick_count;

    // Reports the block owes us, oldest first.
    t_out_item due_reports[$];

    // Knobs shared between the test tasks and the result channel process.
    int send_idle_pct;
    int stall_pct;
    int hold_request;

    // Bookkeeping for the summary and the verdict.
    int mismatches;
    int items_sent;
    int items_accepted;
    int reports_predicted;
    int reports_checked;
    int settings_used;
    int n_valid;
    int n_parity;
    int n_timeout;

    // Free-running clock with a period of two time units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every mismatch goes through here: one line and one count.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // A new hunt clears the shift register, the frame state and the tick count.
    function automatic void restart_hunt();
        in_frame   = 1'b0;
        hunt_reg   = '0;
        bits_seen  = '0;
        data_reg   = '0;
        tick_count = '0;
    endfunction

    // Advance our copy of the deframer by one accepted item and queue any report
    // that it causes.
    function automatic void deframe_item(input t_in_item it);
        t_out_item rep;
        if (it.req_type == REQ_TICK) begin
            // Ticks only matter while hunting; the count saturates at all ones.
            if (!in_frame) begin
                if (tick_count != '1)
                    tick_count = tick_count + 1'b1;
                if (timeout_cfg != '0 && tick_count > timeout_cfg) begin
                    rep.status     = ST_TIMEOUT;
                    rep.data_byte  = '0;
                    rep.parity_bit = 1'b0;
                    due_reports.push_back(rep);
                    reports_predicted++;
                    restart_hunt();
                end
            end
        end else if (!in_frame) begin
            hunt_reg = {hunt_reg[6:0], it.bit_value};
            if (hunt_reg == pattern_cfg) begin
                in_frame  = 1'b1;
                bits_seen = '0;
                data_reg  = '0;
            end
        end else if (bits_seen < DATA_BITS) begin
            data_reg  = {data_reg[6:0], it.bit_value};
            bits_seen = bits_seen + 1'b1;
        end else begin
            // The parity bit closes the frame: data bits plus parity must match
            // the configured sense.
            rep.status     = ((^data_reg ^ it.bit_value) == odd_cfg) ?
                             ST_VALID_FRAME : ST_PARITY_ERROR;
            rep.data_byte  = data_reg;
            rep.parity_bit = it.bit_value;
            due_reports.push_back(rep);
            reports_predicted++;
            restart_hunt();
        end
    endfunction

    // Every item the block accepts is fed to the predictor at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            items_accepted++;
            deframe_item(item_ch.data);
        end
    end

    // Each report the block hands over is compared with the oldest one we owe.
    always @(posedge i_clk) begin : check_reports
        t_out_item want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            reports_checked++;
            if (due_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected report status=%0d data=%02h parity=%0b",
                                          result_ch.data.status, result_ch.data.data_byte,
                                          result_ch.data.parity_bit));
            end else begin
                want = due_reports.pop_front();
                case (want.status)
                    ST_VALID_FRAME:  n_valid++;
                    ST_PARITY_ERROR: n_parity++;
                    default:         n_timeout++;
                endcase
                if (result_ch.data.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_ch.data.status, want.status));
                if (result_ch.data.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data byte %02h, expected %02h",
                                              result_ch.data.data_byte, want.data_byte));
                if (result_ch.data.parity_bit !== want.parity_bit)
                    report_mismatch($sformatf("parity bit %0b, expected %0b",
                                              result_ch.data.parity_bit, want.parity_bit));
            end
        end
    end

    // The result side stalls at random by stall_pct. A hold-off request takes
    // ready low for a counted stretch, which this process owns.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Hang detection: any handshake on either side resets the quiet count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d reports outstanding",
                         QUIET_LIMIT, due_reports.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one item, idling first at random, and return at the edge that takes
    // it. Valid stays high into the next call, so back-to-back items never see a
    // low and a high driven in the same step.
    task automatic send_item(input t_req_type kind, input logic value);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= t_in_item'{req_type: kind, bit_value: value};
        items_sent++;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
    endtask

    // Eight bits, most significant first, with ticks mixed in at tick_pct.
    task automatic send_byte(input logic [7:0] value, input int tick_pct);
        for (int i = 7; i >= 0; i--) begin
            if ($urandom_range(99) < tick_pct)
                send_item(REQ_TICK, 1'($urandom_range(1)));
            send_item(REQ_BIT, value[i]);
        end
    endtask

    // A well-formed frame on the current delimiter; the parity bit is right
    // unless good_parity is clear.
    task automatic send_frame(input logic [7:0] data, input logic good_parity,
                              input int tick_pct);
        send_byte(pattern_cfg, tick_pct);
        send_byte(data, tick_pct);
        send_item(REQ_BIT, ^data ^ odd_cfg ^ ~good_parity);
    endtask

    // Stop offering items and wait until every owed report has arrived and the
    // pipeline has had time to empty behind items that cause no report.
    task automatic drain_reports();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        do begin
            while (due_reports.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE) @(posedge i_clk);
        end while (due_reports.size() != 0);
    endtask

    // Program all three registers and then the unused index, back to back with
    // the write enable held high. Only called while the block is idle.
    task automatic program_regs(input logic [7:0] pattern, input logic odd,
                                input logic [31:0] timeout);
        logic [CFG_IDX_W-1:0]  idx_list[4];
        logic [CFG_DATA_W-1:0] val_list[4];
        idx_list = '{CFG_START_PATTERN, CFG_PARITY_ODD, CFG_TIMEOUT_TICKS, CFG_UNUSED_IDX};
        val_list = '{{24'd0, pattern}, {31'd0, odd}, timeout, $urandom};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[i];
            i_cfg_data <= val_list[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pattern_cfg = pattern;
        odd_cfg     = odd;
        timeout_cfg = timeout;
        settings_used++;
    endtask

    // Hand-picked cases: defaults after reset, ticks with the timeout off, a
    // tick inside a frame, all-ones and all-zeros data, a timeout at its
    // smallest setting and a one-bit delimiter.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        // Defaults: timeout disabled, so this tick only counts.
        send_item(REQ_TICK, 1'b0);
        send_byte(DEFAULT_START_PATTERN, 0);
        // A tick after the delimiter is ignored while the frame is collected.
        send_item(REQ_TICK, 1'b1);
        send_byte(8'hFF, 0);
        send_item(REQ_BIT, 1'b0);
        drain_reports();

        // All-zero delimiter, odd parity and the shortest timeout.
        program_regs(8'h00, 1'b1, 32'd1);
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_TICK, 1'b1);
        // One zero bit matches the cleared shift register straight away.
        send_item(REQ_BIT, 1'b0);
        send_byte(8'h00, 0);
        // Even total parity against an odd setting gives a parity error.
        send_item(REQ_BIT, 1'b0);
        drain_reports();
    endtask

    // One phase of random traffic under one register setting. Most of it is
    // well-formed frames with random content; the rest is tick bursts and
    // stray bits that disturb the hunt.
    task automatic test_random_traffic(input int idle_pct, input int stall,
                                       input logic [7:0] pattern, input logic odd,
                                       input logic [31:0] timeout, input int target);
        int first_item;
        int first_report;
        int pick;
        drain_reports();
        program_regs(pattern, odd, timeout);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        first_item    = items_sent;
        first_report  = reports_predicted;
        while (items_sent - first_item < target || reports_predicted - first_report < 10) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(8'($urandom_range(255)), $urandom_range(3) != 0, 8);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) send_item(REQ_TICK, 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(1, 12)) send_item(REQ_BIT, 1'($urandom_range(1)));
            end
            // Now and then a stretch with no idling on either side.
            if ($urandom_range(15) == 0) begin
                send_idle_pct = 0;
                stall_pct     = 0;
                send_frame(8'($urandom_range(255)), 1'b1, 0);
                send_idle_pct = idle_pct;
                stall_pct     = stall;
            end
        end
    endtask

    // The result side holds off for a long counted stretch while frames keep
    // coming, so the result register fills and the input side must stall. Then
    // the sender pauses until all owed reports are out, then sends two more frames.
    task automatic test_backpressure_fill();
        drain_reports();
        program_regs(8'($urandom_range(255)), 1'($urandom_range(1)), 32'd0);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 150;
        repeat (4) send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), 0);
        drain_reports();
        repeat (2) send_frame(8'($urandom_range(255)), 1'b1, 0);
        drain_reports();
    endtask

    initial begin
        mismatches        = 0;
        items_sent        = 0;
        items_accepted    = 0;
        reports_predicted = 0;
        reports_checked   = 0;
        settings_used     = 0;
        n_valid           = 0;
        n_parity          = 0;
        n_timeout         = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_request      = 0;
        pattern_cfg       = DEFAULT_START_PATTERN;
        odd_cfg           = 1'b0;
        timeout_cfg       = '0;
        restart_hunt();

        // Every input of the block has a known value from time zero.
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        // No idling, all-ones delimiter, even parity, timeout off.
        test_random_traffic(0, 0, 8'hFF, 1'b0, 32'd0, 170);
        // Sender idles; the largest timeout never fires in a run this short.
        test_random_traffic(54, 0, 8'($urandom_range(255)), 1'b1, 32'hFFFF_FFFF, 170);
        // Receiver stalls; all-zero delimiter and a small timeout.
        test_random_traffic(0, 54, 8'h00, 1'b0, $urandom_range(4, 24), 170);
        test_backpressure_fill();
        // Both sides idle; the shortest timeout makes tick bursts bite often.
        test_random_traffic(32, 32, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            32'd1, 170);

        drain_reports();
        if (due_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", due_reports.size()));

        $display("Covered %0d items and %0d reports over %0d register settings.",
                 items_accepted, reports_checked, settings_used);
        $display("Reports seen: %0d valid frames, %0d parity errors, %0d timeouts.",
                 n_valid, n_parity, n_timeout);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dspdf_pkg.sv
hdl/dspdf_if.sv
hdl/delimiter_sync_parity_deframer_top.sv
dv/testbench.sv
